FILE: rtl/ist_pkg.sv
// Shared types, sizes and request codes of the integer set table.
`default_nettype none
package ist_pkg;

	localparam int CAPACITY = 64;
	localparam int POS_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_QUERY  = 2'd2
	} req_code_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic             cap;
		logic [VAL_W-1:0] cmp_value;
		logic             add_go;
		logic             rem_go;
		logic [VAL_W-1:0] wr_value;
		logic [VAL_W-1:0] tail;
	} cell_cmd_t;

	typedef struct packed {
		logic             occ;
		logic             last;
		logic             match;
		logic [VAL_W-1:0] val;
	} cell_stat_t;

endpackage
`default_nettype wire

FILE: rtl/ist_req_if.sv
// Request channel: valid/ready handshake with request code and value.
`default_nettype none
interface ist_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic signed [31:0] value;

	modport source (output valid, output req_type, output value, input ready);
	modport sink (input valid, input req_type, input value, output ready);
endinterface
`default_nettype wire

FILE: rtl/ist_rsp_if.sv
// Result channel: valid/ready handshake with presence, slot, count and full-rejection flag.
`default_nettype none
interface ist_rsp_if;
	logic       valid;
	logic       ready;
	logic       was_present;
	logic [5:0] position;
	logic [6:0] entry_total;
	logic       rejected_full;

	modport source (output valid, output was_present, output position,
		output entry_total, output rejected_full, input ready);
	modport sink (input valid, input was_present, input position,
		input entry_total, input rejected_full, output ready);
endinterface
`default_nettype wire

FILE: rtl/integer_set_table.sv
// The result is registered in the update state, which follows the accept of a request item.
// A new request is taken only in idle, after the last one is updated; the cells compare at
// the accept edge and the slot encode, tail pick and table write happen in the update state.
// A waiting result holds the update cycle until the result item is taken.
// Reset clears the count and all occupancy bits at once; no clearing pass is needed.
`default_nettype none
module integer_set_table (
	input  wire          clk,
	input  wire          arst_n,
	ist_req_if.sink      req,
	ist_rsp_if.source    rsp
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_UPD  = 2'b10
	} state_t;

	localparam int N = ist_pkg::CAPACITY;

	state_t                    state_q;
	logic [1:0]                req_q;
	logic [ist_pkg::VAL_W-1:0] value_q;
	logic [ist_pkg::CNT_W-1:0] count_q;
	logic [ist_pkg::CNT_W-1:0] count_nxt;

	ist_pkg::cell_cmd_t        cmd;
	ist_pkg::cell_stat_t       stat [N];
	logic [N-1:0]              occ_vec;
	logic [N-1:0]              match_vec;

	logic                      accept;
	logic                      go;
	logic                      present;
	logic [ist_pkg::POS_W-1:0] pos;
	logic [ist_pkg::VAL_W-1:0] tail;
	logic                      full;
	logic                      is_add;
	logic                      is_rem;

	logic                      out_valid_q;
	logic                      was_present_q;
	logic [5:0]                position_q;
	logic [6:0]                entry_total_q;
	logic                      rejected_q;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid & req.ready;
	assign go        = (state_q == ST_UPD) & (~out_valid_q | rsp.ready);

	always_comb begin
		is_add = 1'b0;
		is_rem = 1'b0;
		case (req_q)
			ist_pkg::REQ_ADD:    is_add = 1'b1;
			ist_pkg::REQ_REMOVE: is_rem = 1'b1;
			default:             ; // query and the unused code change nothing
		endcase
	end

	// slot encode and tail pick: values are distinct, so at most one match
	always_comb begin
		present = 1'b0;
		pos     = '0;
		tail    = '0;
		for (int i = 0; i < N; i++) begin
			present = present | stat[i].match;
			pos     = pos | ({ist_pkg::POS_W{stat[i].match}} & ist_pkg::POS_W'(i));
			tail    = tail | ({ist_pkg::VAL_W{stat[i].last}} & stat[i].val);
		end
	end

	assign full = (count_q == ist_pkg::CNT_W'(N));

	always_comb begin
		cmd.cap       = accept;
		cmd.cmp_value = req.value;
		cmd.add_go    = go & is_add & ~present & ~full;
		cmd.rem_go    = go & is_rem & present;
		cmd.wr_value  = value_q;
		cmd.tail      = tail;
	end

	always_comb begin
		count_nxt = count_q;
		if (cmd.add_go) begin
			count_nxt = count_q + ist_pkg::CNT_W'(1);
		end else if (cmd.rem_go) begin
			count_nxt = count_q - ist_pkg::CNT_W'(1);
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_cell
		logic left_occ;
		logic right_occ;
		if (g == 0) begin : g_first
			assign left_occ = 1'b1;
		end else begin : g_mid_l
			assign left_occ = stat[g-1].occ;
		end
		if (g == N - 1) begin : g_end
			assign right_occ = 1'b0;
		end else begin : g_mid_r
			assign right_occ = stat[g+1].occ;
		end
		ist_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.left_occ  (left_occ),
			.right_occ (right_occ),
			.stat      (stat[g])
		);
		assign occ_vec[g]   = stat[g].occ;
		assign match_vec[g] = stat[g].match;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_UPD;
				ST_UPD:  if (go) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			count_q <= count_nxt;
			if (go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req.req_type;
			value_q <= req.value;
		end
		if (go) begin
			was_present_q <= present;
			position_q    <= 6'(pos);
			entry_total_q <= 7'(count_nxt);
			rejected_q    <= is_add & ~present & full;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.was_present   = was_present_q;
	assign rsp.position      = position_q;
	assign rsp.entry_total   = entry_total_q;
	assign rsp.rejected_full = rejected_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ist_pkg::CNT_W'(N))
		else $error("entry count above capacity");

	a_occ_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(occ_vec) == 32'(count_q))
		else $error("occupied cells disagree with entry count");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD |-> $onehot0(match_vec))
		else $error("value stored in more than one cell");

	a_result_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_UPD))
		else $error("result raised outside update cycle");

endmodule
`default_nettype wire

FILE: rtl/ist_cell.sv
// One table slot: stored value, occupancy bit and registered match flag.
`default_nettype none
module ist_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  ist_pkg::cell_cmd_t   cmd,
	input  wire                  left_occ,
	input  wire                  right_occ,
	output ist_pkg::cell_stat_t  stat
);

	logic                      occ_q;
	logic                      match_q;
	logic [ist_pkg::VAL_W-1:0] val_q;
	logic                      is_last;
	logic                      is_free_head;

	// occupied cells form a run from slot 0; neighbors mark its ends
	assign is_last      = occ_q & ~right_occ;
	assign is_free_head = ~occ_q & left_occ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (cmd.cap) begin
				match_q <= occ_q & (val_q == cmd.cmp_value);
			end
			if (cmd.add_go && is_free_head) begin
				occ_q <= 1'b1;
			end else if (cmd.rem_go && is_last) begin
				occ_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_go && is_free_head) begin
			val_q <= cmd.wr_value;
		end else if (cmd.rem_go && match_q) begin
			// fill the hole with the last entry
			val_q <= cmd.tail;
		end
	end

	assign stat.occ   = occ_q;
	assign stat.last  = is_last;
	assign stat.match = match_q;
	assign stat.val   = val_q;

endmodule
`default_nettype wire
